>>> hdl/lfp_pkg.sv
// Shared types and constants of the lidar frame parser.
`default_nettype none

package lfp_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int COUNT_W = 4;
    localparam int DATA_BYTES = FRAME_BYTES - 3;
    localparam int STORE_IDX_W = $clog2(DATA_BYTES);
    localparam logic [COUNT_W-1:0] FIRST_DATA_COUNT = 4'd2;
    localparam logic [COUNT_W-1:0] LAST_COUNT = 4'd8;

    localparam logic [7:0] HDR_BYTE = 8'h59;
    localparam logic [15:0] MAX_DIST_RESET = 16'd2200;
    localparam logic signed [16:0] TEMP_OFFSET = 17'sd2731;
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int DIV10_SHIFT = 19;
    localparam int TEMP_W = 14;

    typedef enum logic [1:0] {
        PH_SEARCH1 = 2'd0,
        PH_SEARCH2 = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_CSUM_ERR  = 2'd1,
        ST_RANGE_ERR = 2'd2
    } status_t;

    typedef struct packed {
        logic        csum_ok;
        logic [15:0] range_cm;
        logic [15:0] strength;
        logic [15:0] raw_temp;
    } frame_rec_t;

endpackage

`default_nettype wire

>>> hdl/lfp_byte_if.sv
// Handshake channels for received bytes and for parsed results.
`default_nettype none

interface lfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfp_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [15:0]        range_cm;
    logic [15:0]        strength;
    logic signed [13:0] temperature;

    modport source (output valid, output status, output range_cm, output strength,
                    output temperature, input ready);
    modport sink (input valid, input status, input range_cm, input strength,
                  input temperature, output ready);
endinterface

`default_nettype wire

>>> hdl/lfp_front.sv
// Front end: header search, byte collection and checksum of each frame.
`default_nettype none

module lfp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    lfp_byte_if.sink               rx,
    output logic                   push_valid,
    output lfp_pkg::frame_rec_t    push_rec,
    input  wire logic              push_ready
);

    lfp_pkg::phase_t                   phase_reg, phase_next;
    logic [lfp_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [7:0]                        sum_reg, sum_next;
    logic [7:0]                        store_reg [lfp_pkg::DATA_BYTES];
    logic                              store_we;
    logic [lfp_pkg::STORE_IDX_W-1:0]   store_idx;
    logic                              accept;
    logic                              is_hdr;
    logic                              last_byte;

    assign rx.ready  = push_ready;
    assign accept    = rx.valid && push_ready;
    assign is_hdr    = (rx.rx_byte == lfp_pkg::HDR_BYTE);
    assign last_byte = (count_reg == lfp_pkg::LAST_COUNT);
    assign store_idx = lfp_pkg::STORE_IDX_W'(count_reg - lfp_pkg::FIRST_DATA_COUNT);

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                lfp_pkg::PH_SEARCH2:
                begin
                    phase_next = is_hdr ? lfp_pkg::PH_COLLECT : lfp_pkg::PH_SEARCH1;
                end
                lfp_pkg::PH_COLLECT:
                begin
                    if (last_byte)
                    begin
                        phase_next = lfp_pkg::PH_SEARCH1;
                    end
                end
                default:
                begin
                    phase_next = is_hdr ? lfp_pkg::PH_SEARCH2 : lfp_pkg::PH_SEARCH1;
                end
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        store_we   = 1'b0;
        push_valid = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                lfp_pkg::PH_SEARCH2:
                begin
                    if (is_hdr)
                    begin
                        sum_next   = sum_reg + rx.rx_byte;
                        count_next = lfp_pkg::FIRST_DATA_COUNT;
                    end
                end
                lfp_pkg::PH_COLLECT:
                begin
                    if (last_byte)
                    begin
                        count_next = '0;
                        push_valid = 1'b1;
                    end
                    else
                    begin
                        sum_next   = sum_reg + rx.rx_byte;
                        count_next = count_reg + 1'b1;
                        store_we   = 1'b1;
                    end
                end
                default:
                begin
                    if (is_hdr)
                    begin
                        sum_next   = rx.rx_byte;
                        count_next = lfp_pkg::COUNT_W'(1);
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        push_rec.csum_ok  = (sum_reg == rx.rx_byte);
        push_rec.range_cm = {store_reg[1], store_reg[0]};
        push_rec.strength = {store_reg[3], store_reg[2]};
        push_rec.raw_temp = {store_reg[5], store_reg[4]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lfp_pkg::PH_SEARCH1;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[store_idx] <= rx.rx_byte;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lfp_queue.sv
// Short queue of parsed frames between the front end and the back end.
`default_nettype none

module lfp_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire lfp_pkg::frame_rec_t  push_rec,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      pop_valid,
    output lfp_pkg::frame_rec_t       pop_rec
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lfp_pkg::frame_rec_t mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_rec   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lfp_back.sv
// Back end: range check, temperature conversion and the result register.
`default_nettype none

module lfp_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire lfp_pkg::frame_rec_t  q_rec,
    output logic                      pop,
    input  wire logic [15:0]          max_dist,
    lfp_result_if.source              res
);

    logic                         a_valid_reg;
    lfp_pkg::status_t             a_status_reg, a_status_next;
    logic [15:0]                  a_dist_reg, a_dist_next;
    logic [15:0]                  a_str_reg, a_str_next;
    logic                         a_neg_reg, a_neg_next;
    logic [31:0]                  a_prod_reg, a_prod_next;

    logic                         out_valid_reg;
    logic [1:0]                   out_status_reg;
    logic [15:0]                  out_dist_reg;
    logic [15:0]                  out_str_reg;
    logic [lfp_pkg::TEMP_W-1:0]   out_temp_reg, out_temp_next;

    logic                         adv_a;
    logic                         adv_b;
    logic signed [16:0]           diff;
    logic [15:0]                  mag;
    logic                         range_ok;
    logic [lfp_pkg::TEMP_W-1:0]   quot;

    assign adv_b = !out_valid_reg || res.ready;
    assign adv_a = !a_valid_reg || adv_b;
    assign pop   = q_valid && adv_a;

    always_comb
    begin
        diff        = $signed({1'b0, q_rec.raw_temp}) - lfp_pkg::TEMP_OFFSET;
        a_neg_next  = diff[16];
        mag         = diff[16] ? 16'(-diff) : diff[15:0];
        a_prod_next = 32'(mag) * 32'(lfp_pkg::DIV10_RECIP);
        range_ok    = (q_rec.range_cm != 16'd0) && (q_rec.range_cm <= max_dist);
        if (!q_rec.csum_ok)
        begin
            a_status_next = lfp_pkg::ST_CSUM_ERR;
            a_dist_next   = '0;
            a_str_next    = '0;
        end
        else
        begin
            a_status_next = range_ok ? lfp_pkg::ST_VALID : lfp_pkg::ST_RANGE_ERR;
            a_dist_next   = q_rec.range_cm;
            a_str_next    = q_rec.strength;
        end
    end

    always_comb
    begin
        quot = {1'b0, a_prod_reg[31:lfp_pkg::DIV10_SHIFT]};
        if (a_status_reg == lfp_pkg::ST_CSUM_ERR)
        begin
            out_temp_next = '0;
        end
        else if (a_neg_reg)
        begin
            out_temp_next = '0 - quot;
        end
        else
        begin
            out_temp_next = quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                a_valid_reg <= q_valid;
            end
            if (adv_b)
            begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_status_reg <= a_status_next;
            a_dist_reg   <= a_dist_next;
            a_str_reg    <= a_str_next;
            a_neg_reg    <= a_neg_next;
            a_prod_reg   <= a_prod_next;
        end
        if (adv_b && a_valid_reg)
        begin
            out_status_reg <= a_status_reg;
            out_dist_reg   <= a_dist_reg;
            out_str_reg    <= a_str_reg;
            out_temp_reg   <= out_temp_next;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.range_cm    = out_dist_reg;
    assign res.strength    = out_str_reg;
    assign res.temperature = $signed(out_temp_reg);

endmodule

`default_nettype wire

>>> hdl/lidar_frame_parser.sv
// Top level of the nine-byte lidar serial frame parser.
// The rx channel takes one received serial byte per word. The parser syncs on two
// header bytes, collects the rest of a nine-byte frame and checks its checksum.
// The res channel gives one word per frame: status, distance, strength and the
// temperature in degrees Celsius. A frame with a bad checksum gives zero fields.
// The config port writes the largest valid distance in centimeters; the user must
// write it only while no frame is in flight, since the parser does not enforce this.
// One byte is accepted in every cycle while the queue is not full. The result of a
// frame passes from the queue through a register for the range check and the multiply
// by the reciprocal of ten, then through the sign fix into the result register.
// Frames wait in a two-entry queue between the front end and the back end, so a
// stalled receiver holds rx ready high until that queue fills; ready then stays
// low for every byte until the back end takes a frame out of the queue.
// Reset returns the parser to the header search, empties the queue and the result
// register, and sets the distance limit to 2200 cm.
`default_nettype none

module lidar_frame_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    lfp_byte_if.sink          rx,
    lfp_result_if.source      res,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata
);

    logic [15:0]          max_dist_reg, max_dist_next;
    logic                 push_valid;
    lfp_pkg::frame_rec_t  push_rec;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_valid;
    lfp_pkg::frame_rec_t  q_rec;

    assign max_dist_next = cfg_we ? cfg_wdata : max_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= lfp_pkg::MAX_DIST_RESET;
        end
        else
        begin
            max_dist_reg <= max_dist_next;
        end
    end

    lfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .push_ready (!q_full)
    );

    lfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_rec   (q_rec)
    );

    lfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_rec    (q_rec),
        .pop      (q_pop),
        .max_dist (max_dist_reg),
        .res      (res)
    );

endmodule

`default_nettype wire

>>> hdl/lfp_checker.sv
// Port checker of the lidar frame parser and its binding.
`default_nettype none

module lfp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               res_valid,
    input wire logic               res_ready,
    input wire logic [1:0]         res_status,
    input wire logic [15:0]        res_range_cm,
    input wire logic [15:0]        res_strength,
    input wire logic signed [13:0] res_temperature
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_status == lfp_pkg::ST_VALID) ||
                      (res_status == lfp_pkg::ST_CSUM_ERR) ||
                      (res_status == lfp_pkg::ST_RANGE_ERR))
        else $error("unused status code on result");

    a_csum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == lfp_pkg::ST_CSUM_ERR) |->
            (res_range_cm == 16'd0) && (res_strength == 16'd0) &&
            (res_temperature == 14'sd0))
        else $error("checksum error result carries nonzero fields");

    a_valid_dist: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == lfp_pkg::ST_VALID) |-> res_range_cm != 16'd0)
        else $error("valid reading with zero distance");

endmodule

bind lidar_frame_parser lfp_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_status      (res.status),
    .res_range_cm    (res.range_cm),
    .res_strength    (res.strength),
    .res_temperature (res.temperature)
);

`default_nettype wire

>>> tb/lfp_frame_checker.sv
// Checker that predicts the parsed lidar readings from accepted bytes and compares them.
module lfp_frame_checker
    import lfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    input  logic               rx_ready,
    input  logic [7:0]         rx_byte,
    input  logic               res_valid,
    input  logic               res_ready,
    input  logic [1:0]         res_status,
    input  logic [15:0]        res_range_cm,
    input  logic [15:0]        res_strength,
    input  logic signed [13:0] res_temperature,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    output int                 fail_count,
    output int                 pending,
    output logic               mid_frame,
    output int                 n_valid,
    output int                 n_csum,
    output int                 n_range
);

    localparam int TEMP_DIV = 10;
    localparam int SHOW_MAX = 30;

    typedef struct {
        status_t            status;
        logic [15:0]        range_cm;
        logic [15:0]        strength;
        logic signed [13:0] temperature;
    } reading_t;

    phase_t      phase;
    logic [3:0]  count;
    logic [7:0]  sum;
    logic [7:0]  payload [FRAME_BYTES-2];
    logic [15:0] limit;
    reading_t    readings_due [$];

    function automatic reading_t decode_frame();
        reading_t    r;
        logic [15:0] raw;
        int          t;
        if (sum != payload[FRAME_BYTES-3])
        begin
            r.status = ST_CSUM_ERR;
            r.range_cm = '0;
            r.strength = '0;
            r.temperature = '0;
            return r;
        end
        r.range_cm = {payload[1], payload[0]};
        r.strength = {payload[3], payload[2]};
        raw = {payload[5], payload[4]};
        t = (int'(raw) - int'(TEMP_OFFSET)) / TEMP_DIV;
        r.temperature = t[13:0];
        r.status = (r.range_cm != 0 && r.range_cm <= limit) ? ST_VALID : ST_RANGE_ERR;
        return r;
    endfunction

    function automatic bit absorb_byte(input logic [7:0] b, output reading_t r);
        case (phase)
            PH_SEARCH2:
            begin
                if (b == HDR_BYTE)
                begin
                    sum = sum + b;
                    count = FIRST_DATA_COUNT;
                    phase = PH_COLLECT;
                end
                else
                begin
                    phase = PH_SEARCH1;
                end
                return 1'b0;
            end
            PH_COLLECT:
            begin
                payload[count - FIRST_DATA_COUNT] = b;
                if (count < LAST_COUNT)
                    sum = sum + b;
                count = count + 1'b1;
                if (count == FRAME_BYTES)
                begin
                    phase = PH_SEARCH1;
                    count = '0;
                    r = decode_frame();
                    return 1'b1;
                end
                return 1'b0;
            end
            default:
            begin
                phase = PH_SEARCH1;
                if (b == HDR_BYTE)
                begin
                    sum = b;
                    count = 4'd1;
                    phase = PH_SEARCH2;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report(input string field, input int want, input int got);
        fail_count++;
        if (fail_count <= SHOW_MAX)
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        reading_t fresh;
        if (!rst_n)
        begin
            phase = PH_SEARCH1;
            count = '0;
            sum = '0;
            limit = MAX_DIST_RESET;
            readings_due.delete();
            fail_count = 0;
            n_valid = 0;
            n_csum = 0;
            n_range = 0;
            pending <= 0;
            mid_frame <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit = cfg_wdata;
            if (res_valid && res_ready)
            begin
                if (readings_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOW_MAX)
                        $display("%0t: no reading expected, got status %0d distance %0d",
                                 $time, res_status, res_range_cm);
                end
                else
                begin
                    want = readings_due.pop_front();
                    case (want.status)
                        ST_VALID:    n_valid++;
                        ST_CSUM_ERR: n_csum++;
                        default:     n_range++;
                    endcase
                    if (res_status !== want.status)
                        report("status", want.status, res_status);
                    if (res_range_cm !== want.range_cm)
                        report("range_cm", want.range_cm, res_range_cm);
                    if (res_strength !== want.strength)
                        report("strength", want.strength, res_strength);
                    if (res_temperature !== want.temperature)
                        report("temperature", want.temperature, res_temperature);
                end
            end
            if (rx_valid && rx_ready)
            begin
                if (absorb_byte(rx_byte, fresh))
                    readings_due.push_back(fresh);
            end
            pending <= readings_due.size();
            mid_frame <= (phase == PH_COLLECT);
        end
    end

endmodule

>>> tb/tb_top.sv
// Top of the lidar frame parser testbench: clock, reset, byte and result traffic, verdict.
module tb_top;
    import lfp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BYTES = 165;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic [15:0] cur_limit;
    bit          hold_req;
    bit          gaps_on;
    int          burst_left;
    int          bytes_sent;
    int          frames_sent;
    int          cycles = 0;
    int          fail_count;
    int          pending;
    int          n_valid;
    int          n_csum;
    int          n_range;
    logic        mid_frame;

    lfp_byte_if   rx ();
    lfp_result_if res ();

    lidar_frame_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lfp_frame_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx.valid),
        .rx_ready        (rx.ready),
        .rx_byte         (rx.rx_byte),
        .res_valid       (res.valid),
        .res_ready       (res.ready),
        .res_status      (res.status),
        .res_range_cm    (res.range_cm),
        .res_strength    (res.strength),
        .res_temperature (res.temperature),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .mid_frame       (mid_frame),
        .n_valid         (n_valid),
        .n_csum          (n_csum),
        .n_range         (n_range)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver picks one of four stall patterns at random for each span of cycles.
    initial
    begin
        int mode;
        int span;
        res.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            repeat (span)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    res.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0:       res.ready <= 1'b1;
                    1:       res.ready <= $urandom_range(0, 1);
                    2:       res.ready <= ($urandom_range(0, 3) == 0);
                    default: res.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && burst_left <= 0)
        begin
            rx.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 20);
        end
        rx.valid <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [15:0] range_val, input logic [15:0] stren,
                              input logic [15:0] raw, input bit bad_sum);
        logic [7:0] fb [FRAME_BYTES];
        logic [7:0] sum;
        fb[0] = HDR_BYTE;
        fb[1] = HDR_BYTE;
        fb[2] = range_val[7:0];
        fb[3] = range_val[15:8];
        fb[4] = stren[7:0];
        fb[5] = stren[15:8];
        fb[6] = raw[7:0];
        fb[7] = raw[15:8];
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            sum = sum + fb[i];
        fb[FRAME_BYTES-1] = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
        foreach (fb[i])
            send_byte(fb[i]);
        frames_sent++;
    endtask

    function automatic logic [15:0] pick_distance();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return cur_limit;
            2:       return cur_limit + 16'd1;
            3:       return cur_limit - 16'd1;
            4:       return 16'hFFFF;
            5:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, (cur_limit == 0) ? 1 : cur_limit));
        endcase
    endfunction

    function automatic logic [15:0] pick_raw_temp();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'(int'(TEMP_OFFSET) + $urandom_range(0, 40) - 20);
            3:       return 16'($urandom_range(0, 6000));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Pads a partial frame with zero bytes, then waits until every reading has come.
    task automatic settle();
        bit saved;
        saved = gaps_on;
        gaps_on = 1'b0;
        rx.valid <= 1'b0;
        @(posedge clk);
        while (mid_frame)
        begin
            send_byte(8'h00);
            rx.valid <= 1'b0;
            @(posedge clk);
        end
        gaps_on = saved;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        cur_limit = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(input int n_bytes);
        int goal;
        int kind;
        int n;
        goal = bytes_sent + n_bytes;
        while (bytes_sent < goal)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 72)
                send_frame(pick_distance(), 16'($urandom_range(0, 65535)), pick_raw_temp(), 1'b0);
            else if (kind < 84)
                send_frame(pick_distance(), 16'($urandom_range(0, 65535)), pick_raw_temp(), 1'b1);
            else if (kind < 93)
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_byte(HDR_BYTE);
                n = $urandom_range(0, 254);
                send_byte((8'(n) == HDR_BYTE) ? 8'hFF : 8'(n));
            end
        end
    endtask

    initial
    begin
        rx.valid = 1'b0;
        rx.rx_byte = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        hold_req = 1'b0;
        gaps_on = 1'b1;
        burst_left = 0;
        bytes_sent = 0;
        frames_sent = 0;
        cur_limit = MAX_DIST_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Noise, a broken header, then a good frame, a bad checksum and a zero distance.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR_BYTE);
        send_byte(8'hFF);
        send_frame(16'd100, 16'hFFFF, 16'd0, 1'b0);
        send_frame(16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
        send_frame(16'd0, 16'h1234, 16'd2722, 1'b0);

        random_traffic(PHASE_BYTES);
        settle();
        write_limit(16'd0);
        random_traffic(PHASE_BYTES);
        settle();
        write_limit(16'hFFFF);
        hold_req = 1'b1;
        gaps_on = 1'b0;
        repeat (6) send_frame(pick_distance(), 16'($urandom_range(0, 65535)),
                              pick_raw_temp(), 1'b0);
        gaps_on = 1'b1;
        random_traffic(PHASE_BYTES);
        settle();
        write_limit(16'd1);
        random_traffic(PHASE_BYTES);
        settle();
        write_limit(16'($urandom_range(2, 65534)));
        random_traffic(PHASE_BYTES);
        settle();
        write_limit(MAX_DIST_RESET);
        random_traffic(PHASE_BYTES);
        settle();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d bytes with %0d whole frames under six distance limits.",
                 bytes_sent, frames_sent);
        $display("Readings checked: %0d valid, %0d bad checksum, %0d out of range.",
                 n_valid, n_csum, n_range);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
hdl/lfp_pkg.sv
hdl/lfp_byte_if.sv
hdl/lfp_front.sv
hdl/lfp_queue.sv
hdl/lfp_back.sv
hdl/lidar_frame_parser.sv
hdl/lfp_checker.sv
tb/lfp_frame_checker.sv
tb/tb_top.sv
